// ===== sv/blir_pkg.sv =====
// ----------------------------------------------------------------------------
// blir_pkg
// Shared constants and types of the bounded list block.
// ----------------------------------------------------------------------------
`default_nettype none

package blir_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int COUNT_W      = 5;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // write strobes from the sequencer to the list store
    typedef struct packed {
        logic entry_we;   // value and link of a new entry
        logic link_we;    // relink of a predecessor on remove
        logic free_we;    // push of a released slot
    } blir_we_t;

endpackage

`default_nettype wire

// ===== sv/blir_if.sv =====
// ----------------------------------------------------------------------------
// blir_req_if / blir_rsp_if
// Valid/ready channels of the bounded list block.
// ----------------------------------------------------------------------------
`default_nettype none

interface blir_req_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [31:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface blir_rsp_if;
    logic       valid;
    logic       ready;
    logic       ok;
    logic [4:0] count;
    logic       empty_res;

    modport source (output valid, output ok, output count, output empty_res, input ready);
    modport sink   (input valid, input ok, input count, input empty_res, output ready);
endinterface

`default_nettype wire

// ===== sv/blir_store.sv =====
// ----------------------------------------------------------------------------
// blir_store
// Entry value and link memories plus the free-slot stack, registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module blir_store
    import blir_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int SLOT_W  = $clog2(CAPACITY)
)
(
    input  wire logic                       clk,
    input  wire blir_we_t                   we,
    input  wire logic [SLOT_W-1:0]          entry_addr,
    input  wire logic signed [VALUE_W-1:0]  entry_value,
    input  wire logic [SLOT_W-1:0]          entry_link,
    input  wire logic [SLOT_W-1:0]          link_addr,
    input  wire logic [SLOT_W-1:0]          link_data,
    input  wire logic [SLOT_W-1:0]          rd_addr,
    output logic signed [VALUE_W-1:0]       rd_value,
    output logic [SLOT_W-1:0]               rd_link,
    input  wire logic [SLOT_W-1:0]          free_wr_addr,
    input  wire logic [SLOT_W-1:0]          free_wr_data,
    input  wire logic [SLOT_W-1:0]          free_rd_addr,
    output logic [SLOT_W-1:0]               free_rd_data
);

    logic signed [VALUE_W-1:0] value_mem [CAPACITY];
    logic [SLOT_W-1:0]         link_mem  [CAPACITY];
    logic [SLOT_W-1:0]         free_mem  [CAPACITY];

    logic [SLOT_W-1:0] link_wr_addr;
    logic [SLOT_W-1:0] link_wr_data;

    assign link_wr_addr = we.entry_we ? entry_addr : link_addr;
    assign link_wr_data = we.entry_we ? entry_link : link_data;

    always_ff @(posedge clk)
    begin
        if (we.entry_we)
        begin
            value_mem[entry_addr] <= entry_value;
        end
        rd_value <= value_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we.entry_we || we.link_we)
        begin
            link_mem[link_wr_addr] <= link_wr_data;
        end
        rd_link <= link_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we.free_we)
        begin
            free_mem[free_wr_addr] <= free_wr_data;
        end
        free_rd_data <= free_mem[free_rd_addr];
    end

endmodule

`default_nettype wire

// ===== sv/bounded_list_insert_remove.sv =====
// ----------------------------------------------------------------------------
// bounded_list_insert_remove
// Bounded singly linked list with head insert and remove by value.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item: mode (0 insert at head, 1 remove first match) and
//   a signed 32-bit value. rsp returns one item per request: ok, the entry
//   count after the operation and an empty flag.
//   A full-list insert or an empty-list remove goes straight to the done
//   state with ok low; an insert takes a recycled slot through a free-stack
//   read if one is free, else a never-used slot. A remove walks one entry per
//   cycle through the registered read port of the entry memories and stops
//   at the first match, or after count entries on a miss.
//   One item is in work at a time; req.ready is high only while idle.
//   The result sits in an output register; while rsp is stalled the next
//   item is still taken, and its result waits in the done state until the
//   output register frees up.
//   Reset clears count, head, free-stack depth and high-water mark at once;
//   entry memories need no clearing because every slot is written when it is
//   handed out, from the free stack first, else at the high-water mark.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_list_insert_remove
    import blir_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    blir_req_if.sink  req,
    blir_rsp_if.source rsp
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAPACITY);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_POP  = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]                state_reg, state_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [CNT_W-1:0]          hw_reg, hw_next;
    logic [CNT_W-1:0]          ftop_reg, ftop_next;
    logic [SLOT_W-1:0]         head_reg, head_next;
    logic [SLOT_W-1:0]         cur_reg, cur_next;
    logic [SLOT_W-1:0]         prev_reg, prev_next;
    logic [CNT_W-1:0]          n_reg, n_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic                      fin_ok_reg, fin_ok_next;

    logic                      res_valid_reg;
    logic                      res_ok_reg;
    logic [COUNT_W-1:0]        res_count_reg;
    logic                      res_empty_reg;

    blir_we_t                  we;
    logic [SLOT_W-1:0]         entry_addr;
    logic signed [VALUE_W-1:0] entry_value;
    logic [SLOT_W-1:0]         rd_addr;
    logic signed [VALUE_W-1:0] rd_value;
    logic [SLOT_W-1:0]         rd_link;
    logic [SLOT_W-1:0]         free_rd_data;
    logic [CNT_W-1:0]          ftop_dec;
    logic [CNT_W-1:0]          n_inc;
    logic                      hit;
    logic                      accept;
    logic                      load_res;
    logic [CNT_W+COUNT_W-1:0]  cnt_wide;

    blir_store #(.CAPACITY(CAPACITY)) u_store (
        .clk          (clk),
        .we           (we),
        .entry_addr   (entry_addr),
        .entry_value  (entry_value),
        .entry_link   (head_reg),
        .link_addr    (prev_reg),
        .link_data    (rd_link),
        .rd_addr      (rd_addr),
        .rd_value     (rd_value),
        .rd_link      (rd_link),
        .free_wr_addr (ftop_reg[SLOT_W-1:0]),
        .free_wr_data (cur_reg),
        .free_rd_addr (ftop_dec[SLOT_W-1:0]),
        .free_rd_data (free_rd_data)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign ftop_dec  = ftop_reg - CNT_ONE;
    assign n_inc     = n_reg + CNT_ONE;
    assign hit       = (rd_value == val_reg);
    assign load_res  = (state_reg == ST_DONE) && (!res_valid_reg || rsp.ready);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        hw_next     = hw_reg;
        ftop_next   = ftop_reg;
        head_next   = head_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        n_next      = n_reg;
        val_next    = val_reg;
        fin_ok_next = fin_ok_reg;
        we          = '0;
        entry_addr  = hw_reg[SLOT_W-1:0];
        entry_value = req.value;
        rd_addr     = head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    val_next = req.value;
                    if (req.mode == MODE_INSERT)
                    begin
                        if (cnt_reg == CNT_CAP)
                        begin
                            fin_ok_next = 1'b0;
                            state_next  = ST_DONE;
                        end
                        else if (ftop_reg != '0)
                        begin
                            state_next = ST_POP;
                        end
                        else
                        begin
                            // never-used slot at the high-water mark
                            we.entry_we = 1'b1;
                            head_next   = hw_reg[SLOT_W-1:0];
                            hw_next     = hw_reg + CNT_ONE;
                            cnt_next    = cnt_reg + CNT_ONE;
                            fin_ok_next = 1'b1;
                            state_next  = ST_DONE;
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            fin_ok_next = 1'b0;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            cur_next   = head_reg;
                            n_next     = '0;
                            state_next = ST_WALK;
                        end
                    end
                end
            end
            ST_POP:
            begin
                we.entry_we = 1'b1;
                entry_addr  = free_rd_data;
                entry_value = val_reg;
                head_next   = free_rd_data;
                ftop_next   = ftop_dec;
                cnt_next    = cnt_reg + CNT_ONE;
                fin_ok_next = 1'b1;
                state_next  = ST_DONE;
            end
            ST_WALK:
            begin
                rd_addr = rd_link;
                if (hit)
                begin
                    if (n_reg == '0)
                    begin
                        head_next = rd_link;
                    end
                    else
                    begin
                        we.link_we = 1'b1;
                    end
                    we.free_we  = 1'b1;
                    ftop_next   = ftop_reg + CNT_ONE;
                    cnt_next    = cnt_reg - CNT_ONE;
                    fin_ok_next = 1'b1;
                    state_next  = ST_DONE;
                end
                else if (n_inc == cnt_reg)
                begin
                    fin_ok_next = 1'b0;
                    state_next  = ST_DONE;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = rd_link;
                    n_next    = n_inc;
                end
            end
            ST_DONE:
            begin
                if (load_res)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            hw_reg        <= '0;
            ftop_reg      <= '0;
            head_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            hw_reg    <= hw_next;
            ftop_reg  <= ftop_next;
            head_reg  <= head_next;
            if (load_res)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign cnt_wide = {{COUNT_W{1'b0}}, cnt_reg};

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        n_reg      <= n_next;
        val_reg    <= val_next;
        fin_ok_reg <= fin_ok_next;
        if (load_res)
        begin
            res_ok_reg    <= fin_ok_reg;
            res_count_reg <= cnt_wide[COUNT_W-1:0];
            res_empty_reg <= (cnt_reg == '0);
        end
    end

    assign rsp.valid     = res_valid_reg;
    assign rsp.ok        = res_ok_reg;
    assign rsp.count     = res_count_reg;
    assign rsp.empty_res = res_empty_reg;

endmodule

`default_nettype wire
